>>> rtl/lgmm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the lattice gas move engine.
// Depends on nothing; used by the top level.
package lgmm_pkg;

   // default build sizes
   localparam int LATTICE_MAX_DEF   = 256;
   localparam int MAX_PARTICLES_DEF = 1024;

   // register indexes of the csr port
   localparam logic [2:0] CSR_LATTICE_SIZE    = 3'd0;
   localparam logic [2:0] CSR_MAX_PARTICLES   = 3'd1;
   localparam logic [2:0] CSR_INSERT_PROB     = 3'd2;
   localparam logic [2:0] CSR_MOVE_PROB_ONE   = 3'd3;
   localparam logic [2:0] CSR_MOVE_PROB_TWO   = 3'd4;
   localparam logic [2:0] CSR_MOVE_PROB_THREE = 3'd5;

   // operation codes
   localparam logic OP_MOVE   = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   // result status codes
   localparam logic [2:0] RS_MOVED      = 3'd0;
   localparam logic [2:0] RS_BLOCKED    = 3'd1;
   localparam logic [2:0] RS_ENERGY_REJ = 3'd2;
   localparam logic [2:0] RS_INSERTED   = 3'd3;
   localparam logic [2:0] RS_INSERT_REJ = 3'd4;
   localparam logic [2:0] RS_FULL       = 3'd5;
   localparam logic [2:0] RS_OCCUPIED   = 3'd6;
   localparam logic [2:0] RS_BAD_INDEX  = 3'd7;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POS,
      ST_CNBR,
      ST_PICK,
      ST_TNBR,
      ST_EVAL,
      ST_SETDST,
      ST_INSERT
   } state_type;

   // 8-bit value modulo three by summing base-4 digits
   function automatic logic [1:0] mod3_8(input logic [7:0] v);
      logic [3:0] s;
      logic [1:0] r;
      s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
      unique case (s)
         4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
         4'd1, 4'd4, 4'd7, 4'd10, 4'd13: r = 2'd1;
         default: r = 2'd2;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/lattice_gas_metropolis_move_top.sv
`timescale 1ns / 1ps
// Metropolis lattice gas hop engine: occupancy lattice, position table, sequencer.
// Depends on lgmm_pkg and lgmm_ram.

// A transaction is taken when start is high and busy is low; its one result appears
// on the rsp_ ports for a single cycle with rsp_valid high and cannot be held off.
// After reset the occupancy memory is cleared one site per cycle, all LATTICE_MAX *
// LATTICE_MAX sites, with busy high (csr writes are accepted throughout). A move
// keeps busy high while it runs through its states, and a move with a bad index does
// not raise busy at all; an insert keeps busy high for its ST_INSERT state, or not
// at all when it is refused on count, site range or probability.
// The result strobe is high in the cycle after the last busy cycle, which for an
// item refused at once is the cycle after it is taken. The move time is set by the
// single occupancy read port, which gathers the four neighbors of the old site and
// then the four of the new site one bit per cycle; the evaluate state also clears
// the old site of an accepted move, and ST_SETDST sets the new site and the table entry.
module lattice_gas_metropolis_move_top #(
   parameter int LATTICE_MAX   = lgmm_pkg::LATTICE_MAX_DEF,
   parameter int MAX_PARTICLES = lgmm_pkg::MAX_PARTICLES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic [9:0]         req_particle_index,
   input  logic [7:0]         req_site_x,
   input  logic [7:0]         req_site_y,
   input  logic [7:0]         req_dir_pick,
   input  logic [15:0]        req_random_sample,
   // result
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [7:0]         rsp_new_x,
   output logic [7:0]         rsp_new_y,
   output logic signed [2:0]  rsp_energy_change,
   output logic [10:0]        rsp_particle_count,
   // configuration
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import lgmm_pkg::*;

   localparam int CW    = $clog2(LATTICE_MAX);
   localparam int SW    = (CW + 1 > 9) ? CW + 1 : 9;
   localparam int ODEP  = LATTICE_MAX * LATTICE_MAX;
   localparam int AW    = $clog2(ODEP);
   localparam int PW    = $clog2(MAX_PARTICLES);
   localparam int NW    = PW + 1;
   localparam int MW    = (NW > 11) ? NW : 11;

   // configuration registers
   logic [8:0]  lattice_size_ff;
   logic [10:0] max_particles_ff;
   logic [15:0] insert_prob_ff, prob_one_ff, prob_two_ff, prob_three_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lattice_size_ff  <= 9'd256;
         max_particles_ff <= 11'd1024;
         insert_prob_ff   <= '0;
         prob_one_ff      <= '0;
         prob_two_ff      <= '0;
         prob_three_ff    <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LATTICE_SIZE:    lattice_size_ff  <= csr_wdata[8:0];
            CSR_MAX_PARTICLES:   max_particles_ff <= csr_wdata[10:0];
            CSR_INSERT_PROB:     insert_prob_ff   <= csr_wdata;
            CSR_MOVE_PROB_ONE:   prob_one_ff      <= csr_wdata;
            CSR_MOVE_PROB_TWO:   prob_two_ff      <= csr_wdata;
            CSR_MOVE_PROB_THREE: prob_three_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped side and particle limit
   logic [SW-1:0] side;
   logic [MW-1:0] limit;

   always_comb begin
      if (SW'(lattice_size_ff) < SW'(2)) begin
         side = SW'(2);
      end else if (SW'(lattice_size_ff) > SW'(LATTICE_MAX)) begin
         side = SW'(LATTICE_MAX);
      end else begin
         side = SW'(lattice_size_ff);
      end
      if (MW'(max_particles_ff) > MW'(MAX_PARTICLES)) begin
         limit = MW'(MAX_PARTICLES);
      end else begin
         limit = MW'(max_particles_ff);
      end
   end

   // wrapped neighbor, direction 0 north, 1 east, 2 south, 3 west
   function automatic logic [2*CW-1:0] nbr_of(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y,
                                              input logic [1:0] d,
                                              input logic [SW-1:0] s);
      logic [CW-1:0] nx, ny;
      nx = x;
      ny = y;
      unique case (d)
         2'd0: nx = (x == '0) ? CW'(s - SW'(1)) : x - CW'(1);
         2'd1: ny = (SW'(y) + SW'(1) >= s) ? '0 : y + CW'(1);
         2'd2: nx = (SW'(x) + SW'(1) >= s) ? '0 : x + CW'(1);
         default: ny = (y == '0) ? CW'(s - SW'(1)) : y - CW'(1);
      endcase
      return {nx, ny};
   endfunction

   function automatic logic [AW-1:0] site_addr(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y);
      return AW'(AW'(x) * AW'(LATTICE_MAX) + AW'(y));
   endfunction

   // memories
   logic          occ_we, occ_wdata, occ_rdata;
   logic [AW-1:0] occ_waddr, occ_raddr;
   logic          pos_we;
   logic [PW-1:0] pos_waddr, pos_raddr;
   logic [2*CW-1:0] pos_wdata, pos_rdata;

   lgmm_ram #(.WIDTH(1), .DEPTH(ODEP)) u_occ (
      .clock (clock),
      .we    (occ_we),
      .waddr (occ_waddr),
      .wdata (occ_wdata),
      .raddr (occ_raddr),
      .rdata (occ_rdata)
   );

   lgmm_ram #(.WIDTH(2*CW), .DEPTH(MAX_PARTICLES)) u_pos (
      .clock (clock),
      .we    (pos_we),
      .waddr (pos_waddr),
      .wdata (pos_wdata),
      .raddr (pos_raddr),
      .rdata (pos_rdata)
   );

   // sequencer registers
   state_type      state_ff, state_in;
   logic [1:0]     step_ff, step_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [CW-1:0]  cx_ff, cx_in, cy_ff, cy_in, tx_ff, tx_in, ty_ff, ty_in;
   logic [PW-1:0]  idx_ff, idx_in;
   logic [7:0]     pick_ff, pick_in;
   logic [15:0]    sample_ff, sample_in;
   logic [2:0]     cc_ff, cc_in;
   logic signed [3:0] de_ff, de_in;
   logic [NW-1:0]  cnt_ff, cnt_in;
   logic           rd_pend_ff, rd_pend_in;
   logic [1:0]     rd_slot_ff, rd_slot_in;
   logic [3:0]     nbr_ff, nbr_now;
   logic           rv_ff, rv_in;
   logic [2:0]     rst_ff, rst_in;
   logic [7:0]     rx_ff, rx_in, ry_ff, ry_in;
   logic signed [2:0] rde_ff, rde_in;

   // neighbor bits including the read landing this cycle
   always_comb begin
      nbr_now = nbr_ff;
      if (rd_pend_ff) begin
         nbr_now[rd_slot_ff] = occ_rdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         cnt_ff     <= '0;
         rd_pend_ff <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         cnt_ff     <= cnt_in;
         rd_pend_ff <= rd_pend_in;
         rv_ff      <= rv_in;
      end
      step_ff    <= step_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      tx_ff      <= tx_in;
      ty_ff      <= ty_in;
      idx_ff     <= idx_in;
      pick_ff    <= pick_in;
      sample_ff  <= sample_in;
      cc_ff      <= cc_in;
      de_ff      <= de_in;
      rd_slot_ff <= rd_slot_in;
      nbr_ff     <= nbr_now;
      rst_ff     <= rst_in;
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      rde_ff     <= rde_in;
   end

   // next state, memory ports and result
   always_comb begin
      logic [2*CW-1:0] nb;
      logic [3:0]      freev;
      logic [2:0]      nfree, ct;
      logic [1:0]      k, dsel, seen;
      logic            found, accept;
      logic [15:0]     prob;
      logic signed [3:0] de;

      state_in   = state_ff;
      step_in    = step_ff;
      clr_in     = clr_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      tx_in      = tx_ff;
      ty_in      = ty_ff;
      idx_in     = idx_ff;
      pick_in    = pick_ff;
      sample_in  = sample_ff;
      cc_in      = cc_ff;
      de_in      = de_ff;
      cnt_in     = cnt_ff;
      rd_pend_in = 1'b0;
      rd_slot_in = step_ff;
      rv_in      = 1'b0;
      rst_in     = rst_ff;
      rx_in      = rx_ff;
      ry_in      = ry_ff;
      rde_in     = rde_ff;
      occ_we     = 1'b0;
      occ_waddr  = site_addr(cx_ff, cy_ff);
      occ_wdata  = 1'b0;
      occ_raddr  = site_addr(tx_ff, ty_ff);
      pos_we     = 1'b0;
      pos_waddr  = idx_ff;
      pos_wdata  = {tx_ff, ty_ff};
      pos_raddr  = idx_ff;
      nb         = nbr_of(cx_ff, cy_ff, step_ff, side);
      freev      = ~nbr_now;
      nfree      = 3'($countones(freev));
      ct         = 3'($countones(nbr_now));
      k          = 2'd0;
      dsel       = 2'd0;
      seen       = 2'd0;
      found      = 1'b0;
      accept     = 1'b0;
      prob       = prob_one_ff;
      de         = 4'sd0;

      unique case (state_ff)
         // sweep the lattice to zero after reset
         ST_CLEAR: begin
            occ_we    = 1'b1;
            occ_waddr = clr_ff;
            occ_wdata = 1'b0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(ODEP - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (start) begin
               pick_in   = req_dir_pick;
               sample_in = req_random_sample;
               tx_in     = CW'(req_site_x);
               ty_in     = CW'(req_site_y);
               idx_in    = PW'(req_particle_index);
               rx_in     = 8'd0;
               ry_in     = 8'd0;
               rde_in    = 3'sd0;
               pos_raddr = PW'(req_particle_index);
               occ_raddr = site_addr(CW'(req_site_x), CW'(req_site_y));
               if (req_operation == OP_INSERT) begin
                  rx_in = req_site_x;
                  ry_in = req_site_y;
                  priority if (MW'(cnt_ff) >= limit) begin
                     rv_in  = 1'b1;
                     rst_in = RS_FULL;
                  end else if (SW'(req_site_x) >= side || SW'(req_site_y) >= side) begin
                     rv_in  = 1'b1;
                     rst_in = RS_BAD_INDEX;
                  end else if (!(insert_prob_ff > req_random_sample)) begin
                     rv_in  = 1'b1;
                     rst_in = RS_INSERT_REJ;
                  end else begin
                     state_in = ST_INSERT;
                  end
               end else if (MW'(req_particle_index) >= MW'(cnt_ff) ||
                            MW'(req_particle_index) >= limit) begin
                  rv_in  = 1'b1;
                  rst_in = RS_BAD_INDEX;
               end else begin
                  state_in = ST_POS;
               end
            end
         end

         // occupancy of the insert site is back
         ST_INSERT: begin
            state_in = ST_IDLE;
            rv_in    = 1'b1;
            if (occ_rdata) begin
               rst_in = RS_OCCUPIED;
            end else begin
               occ_we    = 1'b1;
               occ_waddr = site_addr(tx_ff, ty_ff);
               occ_wdata = 1'b1;
               pos_we    = 1'b1;
               pos_waddr = PW'(cnt_ff);
               cnt_in    = cnt_ff + NW'(1);
               rst_in    = RS_INSERTED;
            end
         end

         // particle position is back
         ST_POS: begin
            cx_in    = pos_rdata[2*CW-1:CW];
            cy_in    = pos_rdata[CW-1:0];
            step_in  = 2'd0;
            state_in = ST_CNBR;
         end

         // read the four neighbors of the old site
         ST_CNBR: begin
            occ_raddr  = site_addr(nb[2*CW-1:CW], nb[CW-1:0]);
            rd_pend_in = 1'b1;
            step_in    = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = ST_PICK;
            end
         end

         // choose the free neighbor
         ST_PICK: begin
            unique case (nfree)
               3'd2:    k = 2'(pick_ff[0]);
               3'd3:    k = mod3_8(pick_ff);
               3'd4:    k = pick_ff[1:0];
               default: k = 2'd0;
            endcase
            for (int d = 0; d < 4; d++) begin
               if (freev[d] && !found) begin
                  if (seen == k) begin
                     dsel  = 2'(d);
                     found = 1'b1;
                  end else begin
                     seen = seen + 2'd1;
                  end
               end
            end
            nb      = nbr_of(cx_ff, cy_ff, dsel, side);
            tx_in   = nb[2*CW-1:CW];
            ty_in   = nb[CW-1:0];
            cc_in   = ct;
            step_in = 2'd0;
            if (nfree == 3'd0) begin
               rv_in    = 1'b1;
               rst_in   = RS_BLOCKED;
               rx_in    = 8'(cx_ff);
               ry_in    = 8'(cy_ff);
               rde_in   = 3'sd0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_TNBR;
            end
         end

         // read the four neighbors of the new site
         ST_TNBR: begin
            nb         = nbr_of(tx_ff, ty_ff, step_ff, side);
            occ_raddr  = site_addr(nb[2*CW-1:CW], nb[CW-1:0]);
            rd_pend_in = 1'b1;
            step_in    = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = ST_EVAL;
            end
         end

         // energy change and acceptance
         ST_EVAL: begin
            de = 4'sd1 + $signed({1'b0, cc_ff}) - $signed({1'b0, ct});
            unique case (de)
               4'sd1:   prob = prob_one_ff;
               4'sd2:   prob = prob_two_ff;
               default: prob = prob_three_ff;
            endcase
            accept = (de <= 4'sd0) || (prob > sample_ff);
            de_in  = de;
            if (accept) begin
               occ_we    = 1'b1;
               occ_waddr = site_addr(cx_ff, cy_ff);
               occ_wdata = 1'b0;
               state_in  = ST_SETDST;
            end else begin
               rv_in    = 1'b1;
               rst_in   = RS_ENERGY_REJ;
               rx_in    = 8'(cx_ff);
               ry_in    = 8'(cy_ff);
               rde_in   = 3'(de);
               state_in = ST_IDLE;
            end
         end

         // occupy the new site and update the table
         ST_SETDST: begin
            occ_we    = 1'b1;
            occ_waddr = site_addr(tx_ff, ty_ff);
            occ_wdata = 1'b1;
            pos_we    = 1'b1;
            pos_waddr = idx_ff;
            rv_in     = 1'b1;
            rst_in    = RS_MOVED;
            rx_in     = 8'(tx_ff);
            ry_in     = 8'(ty_ff);
            rde_in    = 3'(de_ff);
            state_in  = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rv_ff;
   assign rsp_status         = rst_ff;
   assign rsp_new_x          = rx_ff;
   assign rsp_new_y          = ry_ff;
   assign rsp_energy_change  = rde_ff;
   assign rsp_particle_count = 11'(cnt_ff);

endmodule

>>> rtl/lgmm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lgmm_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the lattice gas hop engine: directed and random moves and
// inserts, predicted by a local lattice model. Depends on lgmm_pkg and the rtl top.
module testbench;
   import lgmm_pkg::*;

   typedef struct {
      logic        op;
      logic [9:0]  idx;
      logic [7:0]  sx;
      logic [7:0]  sy;
      logic [7:0]  pick;
      logic [15:0] sample;
   } hop_req_type;

   typedef struct {
      logic [2:0]        status;
      logic [7:0]        nx;
      logic [7:0]        ny;
      logic signed [2:0] de;
      logic [10:0]       cnt;
   } hop_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_operation = OP_MOVE;
   logic [9:0] req_particle_index = '0;
   logic [7:0] req_site_x = '0;
   logic [7:0] req_site_y = '0;
   logic [7:0] req_dir_pick = '0;
   logic [15:0] req_random_sample = '0;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [7:0] rsp_new_x;
   logic [7:0] rsp_new_y;
   logic signed [2:0] rsp_energy_change;
   logic [10:0] rsp_particle_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   lattice_gas_metropolis_move_top uut (.*);

   always #5 clock = ~clock;

   // local copy of lattice, position table and registers
   bit         occ [0:65535];
   logic [7:0] pos_x [0:1023];
   logic [7:0] pos_y [0:1023];
   int         held = 0;
   int         side_reg = 256;
   int         limit_reg = 1024;
   int         prob_reg [0:5];

   hop_req_type pending_hops [$];
   hop_rsp_type expected_results [$];
   int       errors = 0;
   int       idle_pct = 32;

   function automatic int side_now();
      if (side_reg < 2) return 2;
      if (side_reg > 256) return 256;
      return side_reg;
   endfunction

   function automatic int limit_now();
      return (limit_reg > 1024) ? 1024 : limit_reg;
   endfunction

   // neighbor site in direction d: north, east, south, west
   function automatic void step_site(input int s, input int x, input int y, input int d,
                                     output int nx, output int ny);
      nx = x;
      ny = y;
      case (d)
         0: nx = (x == 0) ? s - 1 : x - 1;
         1: ny = (y + 1 >= s) ? 0 : y + 1;
         2: nx = (x + 1 >= s) ? 0 : x + 1;
         default: ny = (y == 0) ? s - 1 : y - 1;
      endcase
   endfunction

   function automatic int busy_around(input int s, input int x, input int y);
      int n, nx, ny;
      n = 0;
      for (int d = 0; d < 4; d++) begin
         step_site(s, x, y, d, nx, ny);
         n += occ[nx * 256 + ny];
      end
      return n;
   endfunction

   // compute the outcome of one hop or insert and update the local lattice
   function automatic hop_rsp_type predict_hop(input hop_req_type r);
      hop_rsp_type e;
      int s, m, cx, cy, nfree, k, tx, ty, nx, ny, de, pr;
      int fx [4];
      int fy [4];
      s = side_now();
      m = limit_now();
      de = 0;
      e.nx = '0;
      e.ny = '0;
      if (r.op == OP_INSERT) begin
         e.nx = r.sx;
         e.ny = r.sy;
         if (held >= m) e.status = RS_FULL;
         else if (r.sx >= s || r.sy >= s) e.status = RS_BAD_INDEX;
         else if (!(prob_reg[CSR_INSERT_PROB] > r.sample)) e.status = RS_INSERT_REJ;
         else if (occ[r.sx * 256 + r.sy]) e.status = RS_OCCUPIED;
         else begin
            occ[r.sx * 256 + r.sy] = 1'b1;
            pos_x[held] = r.sx;
            pos_y[held] = r.sy;
            held++;
            e.status = RS_INSERTED;
         end
      end else if (r.idx >= held || r.idx >= m) begin
         e.status = RS_BAD_INDEX;
      end else begin
         cx = pos_x[r.idx];
         cy = pos_y[r.idx];
         e.nx = 8'(cx);
         e.ny = 8'(cy);
         nfree = 0;
         for (int d = 0; d < 4; d++) begin
            step_site(s, cx, cy, d, nx, ny);
            if (!occ[nx * 256 + ny]) begin
               fx[nfree] = nx;
               fy[nfree] = ny;
               nfree++;
            end
         end
         if (nfree == 0) begin
            e.status = RS_BLOCKED;
         end else begin
            k = r.pick % nfree;
            tx = fx[k];
            ty = fy[k];
            // the vacated site is counted around the target
            de = 1 + busy_around(s, cx, cy) - busy_around(s, tx, ty);
            pr = (de == 1) ? prob_reg[CSR_MOVE_PROB_ONE] :
                 (de == 2) ? prob_reg[CSR_MOVE_PROB_TWO] : prob_reg[CSR_MOVE_PROB_THREE];
            if (de <= 0 || pr > r.sample) begin
               occ[cx * 256 + cy] = 1'b0;
               occ[tx * 256 + ty] = 1'b1;
               pos_x[r.idx] = 8'(tx);
               pos_y[r.idx] = 8'(ty);
               e.nx = 8'(tx);
               e.ny = 8'(ty);
               e.status = RS_MOVED;
            end else begin
               e.status = RS_ENERGY_REJ;
            end
         end
      end
      e.de = 3'(de);
      e.cnt = 11'(held);
      return e;
   endfunction

   // driver: present queued transactions, hold start until accepted
   always @(posedge clock) begin
      logic taken;
      hop_req_type nxt;
      taken = start && !busy;
      if (taken) begin
         expected_results.insert(expected_results.size(),
                                 predict_hop(pending_hops.pop_front()));
      end
      if (reset) begin
         start <= 1'b0;
      end else if (start && !taken) begin
         start <= 1'b1;
      end else if (pending_hops.size() > 0 && $urandom_range(99) >= idle_pct) begin
         nxt = pending_hops[0];
         start <= 1'b1;
         req_operation <= nxt.op;
         req_particle_index <= nxt.idx;
         req_site_x <= nxt.sx;
         req_site_y <= nxt.sy;
         req_dir_pick <= nxt.pick;
         req_random_sample <= nxt.sample;
      end else begin
         start <= 1'b0;
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      hop_rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result status %0d", $time, rsp_status);
            errors++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status exp %0d got %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_new_x !== e.nx) begin
               $display("%0t: new_x exp %0d got %0d", $time, e.nx, rsp_new_x);
               errors++;
            end
            if (rsp_new_y !== e.ny) begin
               $display("%0t: new_y exp %0d got %0d", $time, e.ny, rsp_new_y);
               errors++;
            end
            if (rsp_energy_change !== e.de) begin
               $display("%0t: energy exp %0d got %0d", $time, e.de, rsp_energy_change);
               errors++;
            end
            if (rsp_particle_count !== e.cnt) begin
               $display("%0t: count exp %0d got %0d", $time, e.cnt, rsp_particle_count);
               errors++;
            end
         end
      end
   end

   // one csr transaction, caller sits at a clock edge
   task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_LATTICE_SIZE:  side_reg = value & 16'h1FF;
         CSR_MAX_PARTICLES: limit_reg = value & 16'h7FF;
         default:           prob_reg[index] = value;
      endcase
   endtask

   task automatic set_regs(input int side, input int limit, input int pi,
                           input int p1, input int p2, input int p3);
      write_reg(CSR_LATTICE_SIZE, 16'(side));
      write_reg(CSR_MAX_PARTICLES, 16'(limit));
      write_reg(CSR_INSERT_PROB, 16'(pi));
      write_reg(CSR_MOVE_PROB_ONE, 16'(p1));
      write_reg(CSR_MOVE_PROB_TWO, 16'(p2));
      write_reg(CSR_MOVE_PROB_THREE, 16'(p3));
      csr_valid <= 1'b0;
   endtask

   // sender pause until every request is sent and every result is back, then an idle pause
   task automatic drain();
      do @(posedge clock);
      while (pending_hops.size() != 0 || start || expected_results.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic queue_hop(input logic op, input int idx, input int sx, input int sy,
                            input int pick, input int sample);
      hop_req_type r;
      r.op = op;
      r.idx = 10'(idx);
      r.sx = 8'(sx);
      r.sy = 8'(sy);
      r.pick = 8'(pick);
      r.sample = 16'(sample);
      pending_hops.insert(pending_hops.size(), r);
   endtask

   function automatic int pick_prob();
      case ($urandom_range(3))
         0: return 0;
         1: return 16'hFFFF;
         default: return $urandom_range(16'hFFFF);
      endcase
   endfunction

   initial begin
      int sides [8] = '{0, 2, 3, 4, 5, 16, 256, 511};
      int limits [6] = '{0, 6, 40, 300, 1024, 2047};
      int s;
      for (int i = 0; i < 6; i++) prob_reg[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: insert rejected on probability, moves with empty table
      queue_hop(OP_INSERT, 0, 0, 0, 0, 0);
      queue_hop(OP_MOVE, 0, 0, 0, 0, 0);
      drain();

      // tiny wrapped lattice, size below two acts as two
      set_regs(0, 3, 16'hFFFF, 0, 0, 0);
      queue_hop(OP_INSERT, 0, 0, 0, 0, 0);
      queue_hop(OP_INSERT, 0, 0, 0, 0, 0);          // occupied
      queue_hop(OP_INSERT, 0, 2, 0, 0, 0);          // outside lattice
      queue_hop(OP_INSERT, 0, 1, 1, 0, 16'hFFFF);   // probability not above sample
      queue_hop(OP_INSERT, 0, 1, 1, 0, 0);
      queue_hop(OP_INSERT, 0, 0, 1, 0, 0);
      queue_hop(OP_INSERT, 0, 1, 0, 0, 0);          // table full
      queue_hop(OP_MOVE, 3, 0, 0, 0, 0);            // index not below count
      queue_hop(OP_MOVE, 1023, 0, 0, 0, 0);
      queue_hop(OP_MOVE, 0, 0, 0, 255, 0);
      queue_hop(OP_MOVE, 2, 0, 0, 7, 16'hFFFF);
      drain();

      // fill the lattice so every move is blocked, then shrink the maximum
      set_regs(2, 4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      for (int x = 0; x < 2; x++)
         for (int y = 0; y < 2; y++) queue_hop(OP_INSERT, 0, x, y, 0, 16'hFFFE);
      queue_hop(OP_MOVE, 1, 0, 0, 0, 0);
      drain();
      set_regs(256, 2, 16'hFFFF, 0, 0, 0);
      queue_hop(OP_MOVE, 2, 0, 0, 0, 0);            // index not below maximum
      queue_hop(OP_MOVE, 1, 0, 0, 3, 0);
      drain();

      // particle far out, then lattice shrunk beneath it
      set_regs(256, 6, 16'hFFFF, 0, 0, 0);
      queue_hop(OP_INSERT, 0, 255, 255, 0, 0);
      queue_hop(OP_INSERT, 0, 128, 64, 0, 0);
      drain();
      set_regs(4, 6, 0, 0, 0, 0);
      queue_hop(OP_MOVE, 4, 0, 0, 1, 0);
      queue_hop(OP_MOVE, 5, 0, 0, 2, 0);
      drain();

      // random phases with new settings each time
      for (int ph = 0; ph < 10; ph++) begin
         idle_pct = (ph < 4) ? 32 : (ph < 7) ? 58 : 0;
         set_regs(sides[$urandom_range(7)], limits[$urandom_range(5)],
                  ($urandom_range(3) == 0) ? 0 : pick_prob() | 16'h8000,
                  pick_prob(), pick_prob(), pick_prob());
         s = side_now();
         for (int i = 0; i < 150; i++) begin
            if ($urandom_range(99) < 30)
               if ($urandom_range(9) < 8)
                  queue_hop(OP_INSERT, $urandom_range(1023), $urandom_range(s - 1),
                            $urandom_range(s - 1), $urandom, $urandom);
               else
                  queue_hop(OP_INSERT, $urandom_range(1023), $urandom_range(255),
                            $urandom_range(255), $urandom, $urandom);
            else if ($urandom_range(19) == 0)
               queue_hop(OP_MOVE, $urandom_range(1023), $urandom, $urandom,
                         $urandom, $urandom);
            else
               queue_hop(OP_MOVE, $urandom_range((held > 1020) ? 1023 : held + 2),
                         $urandom, $urandom, $urandom, $urandom);
         end
         drain();
      end

      if (errors == 0 && expected_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // overall time limit
   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
